>>> hw/rtl/tsts_pkg.sv
`default_nettype none

package tsts_pkg;

  // Table geometry.
  localparam int unsigned SLOTS    = 16;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);

  // Field widths fixed by the interface.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned PID_W    = 22;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned PEND_W   = 8;
  localparam int unsigned PEND_MAX = 255;

  // One memory word holds the process id above the status.
  localparam int unsigned WORD_W   = PID_W + ST_W;

  // Ring start of an add is (current + pending) mod SLOTS, reduced by
  // restoring subtraction of SLOTS << k for k = MOD_STEPS-1 down to 0.
  localparam int unsigned MOD_STEPS = $clog2((SLOTS + PEND_MAX) / SLOTS + 1);
  localparam int unsigned MODK_W    = $clog2(MOD_STEPS + 1);
  localparam int unsigned SUM_W     = SLOT_W + MOD_STEPS + 1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_TAKE   = 3'd1,
    OP_SET    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_FIND   = 3'd4,
    OP_BUMP   = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_PENDING    = 2'd0,
    ST_WAITING    = 2'd1,
    ST_PROCESSING = 2'd2,
    ST_FINISHED   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_MOD,
    FSM_SCAN,
    FSM_UPDATE
  } fsm_e;

endpackage

`default_nettype wire

>>> hw/rtl/tsts_ram.sv
`default_nettype none

module tsts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/task_slot_table_scheduler.sv
`default_nettype none

// Task slot table scheduler: a ring of SLOTS task slots, each with a used mark
// (flip-flops) and a process id and status (one synchronous RAM word). The
// block works on one operation at a time and returns exactly one result per
// input transfer. Bump pending, unknown opcodes, add on a full table and
// take-next with a zero pending count go from the input transfer straight
// to the final step. Take-next, set status, remove and find walk the ring
// one slot per cycle through the RAM read port; add first reduces current +
// pending modulo SLOTS by restoring subtraction and then walks the used
// marks. The next input transfer is taken only once the final step has
// loaded the previous result. The pace is set by the single RAM read port,
// one slot per cycle. A finished result sits in an output register, so the
// next input transfer is taken while the previous result still waits; that
// operation only stalls at its final step until the output register is
// free. All RAM writes happen in that final step, before the next operation
// can read, so no forwarding is needed. The pending count saturates at 255.
module task_slot_table_scheduler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tsts_pkg::OP_W-1:0]   opcode_i,
  input  logic [tsts_pkg::PID_W-1:0]  task_pid_i,
  input  logic [tsts_pkg::ST_W-1:0]   new_status_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic [tsts_pkg::IDX_W-1:0]  slot_index_o,
  output logic [tsts_pkg::PID_W-1:0]  found_pid_o,
  output logic [tsts_pkg::PEND_W-1:0] pending_now_o
);

  import tsts_pkg::*;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  // Control state.
  fsm_e               state_q, state_d;
  logic [SLOTS-1:0]   used_q, used_d;
  logic [SLOT_W-1:0]  cur_q, cur_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic [CNT_W-1:0]   used_cnt_q, used_cnt_d;
  logic [MODK_W-1:0]  mod_k_q, mod_k_d;
  logic [SLOT_W-1:0]  issue_addr_q, issue_addr_d;
  logic [CNT_W-1:0]   issue_cnt_q, issue_cnt_d;
  logic               chk_vld_q, chk_vld_d;
  logic               chk_last_q, chk_last_d;
  logic [SLOT_W-1:0]  chk_addr_q, chk_addr_d;
  logic               hit_q, hit_d;
  logic               out_valid_q, out_valid_d;

  // Operation and result payload.
  logic [OP_W-1:0]    op_q;
  logic [PID_W-1:0]   pid_q;
  status_e            st_q;
  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [WORD_W-1:0]  data_q, data_d;
  logic               ok_q, ok_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [PID_W-1:0]   fpid_q, fpid_d;
  logic [PEND_W-1:0]  pnow_q, pnow_d;

  // Memory port.
  logic               ram_we;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [WORD_W-1:0]  ram_rdata;

  logic               in_xfer;
  logic               chk_used;
  status_e            rd_st;
  logic [PID_W-1:0]   rd_pid;
  logic               hit_cond;
  status_e            dq_st;
  logic [PID_W-1:0]   dq_pid;
  logic [PEND_W-1:0]  pend_inc;
  logic [SUM_W-1:0]   mod_div;
  logic [SUM_W-1:0]   mod_rem;
  logic               ok_v;
  logic [PID_W-1:0]   fpid_v;

  assign in_ready_o = (state_q == FSM_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  tsts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (issue_addr_q),
    .rdata_o (ram_rdata)
  );

  // The entry checked in this cycle is the one whose read was issued in the
  // cycle before; its used mark comes straight from the flip-flops.
  assign chk_used = used_q[chk_addr_q];
  assign rd_st    = status_e'(ram_rdata[ST_W-1:0]);
  assign rd_pid   = ram_rdata[WORD_W-1:ST_W];
  assign dq_st    = status_e'(data_q[ST_W-1:0]);
  assign dq_pid   = data_q[WORD_W-1:ST_W];
  assign pend_inc = (pend_q == PEND_W'(PEND_MAX)) ? pend_q : pend_q + 1'b1;
  assign mod_div  = SUM_W'(SLOTS) << mod_k_q;
  assign mod_rem  = (rem_q >= mod_div) ? rem_q - mod_div : rem_q;

  always_comb begin
    unique case (op_q) inside
      OP_ADD: begin
        hit_cond = !chk_used;
      end
      OP_TAKE: begin
        hit_cond = chk_used && (rd_st == ST_PENDING || rd_st == ST_WAITING);
      end
      OP_SET, OP_REMOVE, OP_FIND: begin
        hit_cond = chk_used && (rd_pid == pid_q);
      end
      default: begin
        hit_cond = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    cur_d        = cur_q;
    pend_d       = pend_q;
    used_cnt_d   = used_cnt_q;
    mod_k_d      = mod_k_q;
    issue_addr_d = issue_addr_q;
    issue_cnt_d  = issue_cnt_q;
    chk_vld_d    = 1'b0;
    chk_last_d   = chk_last_q;
    chk_addr_d   = chk_addr_q;
    hit_d        = hit_q;
    rem_d        = rem_q;
    slot_d       = slot_q;
    data_d       = data_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ok_d         = ok_q;
    idx_d        = idx_q;
    fpid_d       = fpid_q;
    pnow_d       = pnow_q;
    ram_we       = 1'b0;
    ram_wdata    = data_q;
    ram_re       = 1'b0;
    ok_v         = 1'b0;
    fpid_v       = '0;

    unique case (state_q)
      FSM_IDLE: begin
        if (in_xfer) begin
          hit_d       = 1'b0;
          slot_d      = '0;
          issue_cnt_d = '0;
          unique case (opcode_i) inside
            OP_ADD: begin
              if (used_cnt_q != CNT_W'(SLOTS)) begin
                rem_d   = SUM_W'(cur_q) + SUM_W'(pend_q);
                mod_k_d = MODK_W'(MOD_STEPS - 1);
                state_d = FSM_MOD;
              end else begin
                state_d = FSM_UPDATE;
              end
            end
            OP_TAKE: begin
              if (pend_q != '0) begin
                issue_addr_d = cur_q;
                state_d      = FSM_SCAN;
              end else begin
                state_d = FSM_UPDATE;
              end
            end
            OP_SET, OP_REMOVE, OP_FIND: begin
              issue_addr_d = '0;
              state_d      = FSM_SCAN;
            end
            default: begin
              state_d = FSM_UPDATE;
            end
          endcase
        end
      end

      FSM_MOD: begin
        rem_d = mod_rem;
        if (mod_k_q == '0) begin
          issue_addr_d = mod_rem[SLOT_W-1:0];
          state_d      = FSM_SCAN;
        end else begin
          mod_k_d = mod_k_q - 1'b1;
        end
      end

      FSM_SCAN: begin
        ram_re = (issue_cnt_q != CNT_W'(SLOTS));
        if (ram_re) begin
          issue_addr_d = next_slot(issue_addr_q);
          issue_cnt_d  = issue_cnt_q + 1'b1;
        end
        chk_vld_d  = ram_re;
        chk_addr_d = issue_addr_q;
        chk_last_d = (issue_cnt_q == CNT_W'(SLOTS - 1));
        if (chk_vld_q && hit_cond) begin
          hit_d     = 1'b1;
          slot_d    = chk_addr_q;
          data_d    = ram_rdata;
          chk_vld_d = 1'b0;
          state_d   = FSM_UPDATE;
        end else if (chk_vld_q && chk_last_q) begin
          chk_vld_d = 1'b0;
          state_d   = FSM_UPDATE;
        end
      end

      FSM_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          case (op_q) inside
            OP_ADD: begin
              if (hit_q) begin
                used_d[slot_q] = 1'b1;
                ram_we         = 1'b1;
                ram_wdata      = {pid_q, ST_PENDING};
                pend_d         = pend_inc;
                used_cnt_d     = used_cnt_q + 1'b1;
                ok_v           = 1'b1;
                fpid_v         = pid_q;
              end
            end
            OP_TAKE: begin
              if (hit_q) begin
                ram_we    = 1'b1;
                ram_wdata = {dq_pid, ST_PROCESSING};
                cur_d     = next_slot(slot_q);
                pend_d    = pend_q - 1'b1;
                ok_v      = 1'b1;
                fpid_v    = dq_pid;
              end
            end
            OP_SET: begin
              if (hit_q && dq_st != st_q) begin
                ram_we    = 1'b1;
                ram_wdata = {dq_pid, st_q};
                if (st_q == ST_PENDING || st_q == ST_WAITING) begin
                  pend_d = pend_inc;
                end
                ok_v   = 1'b1;
                fpid_v = dq_pid;
              end
            end
            OP_REMOVE: begin
              if (hit_q) begin
                used_d[slot_q] = 1'b0;
                if (used_cnt_q != '0) begin
                  used_cnt_d = used_cnt_q - 1'b1;
                end
                ok_v   = 1'b1;
                fpid_v = dq_pid;
              end
            end
            OP_FIND: begin
              if (hit_q) begin
                ok_v   = 1'b1;
                fpid_v = dq_pid;
              end
            end
            OP_BUMP: begin
              pend_d = pend_inc;
              ok_v   = 1'b1;
            end
            default: begin
              ok_v = 1'b0;
            end
          endcase
          ok_d        = ok_v;
          idx_d       = (ok_v && op_q != OP_BUMP) ? IDX_W'(slot_q) : '0;
          fpid_d      = fpid_v;
          pnow_d      = pend_d;
          out_valid_d = 1'b1;
          state_d     = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      used_q       <= '0;
      cur_q        <= '0;
      pend_q       <= '0;
      used_cnt_q   <= '0;
      mod_k_q      <= '0;
      issue_addr_q <= '0;
      issue_cnt_q  <= '0;
      chk_vld_q    <= 1'b0;
      chk_last_q   <= 1'b0;
      chk_addr_q   <= '0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      cur_q        <= cur_d;
      pend_q       <= pend_d;
      used_cnt_q   <= used_cnt_d;
      mod_k_q      <= mod_k_d;
      issue_addr_q <= issue_addr_d;
      issue_cnt_q  <= issue_cnt_d;
      chk_vld_q    <= chk_vld_d;
      chk_last_q   <= chk_last_d;
      chk_addr_q   <= chk_addr_d;
      hit_q        <= hit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= opcode_i;
      pid_q <= task_pid_i;
      st_q  <= status_e'(new_status_i);
    end
    rem_q  <= rem_d;
    slot_q <= slot_d;
    data_q <= data_d;
    ok_q   <= ok_d;
    idx_q  <= idx_d;
    fpid_q <= fpid_d;
    pnow_q <= pnow_d;
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign slot_index_o  = idx_q;
  assign found_pid_o   = fpid_q;
  assign pending_now_o = pnow_q;

  // The used count always matches the number of used marks.
  a_used_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q == CNT_W'($countones(used_q)))
    else $error("used count out of step with used marks");

  // A new result appears only out of the final step of an operation.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == FSM_UPDATE))
    else $error("result loaded outside the final step");

  // An add that reaches its final step with a hit always claims a free slot.
  a_add_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_UPDATE && hit_q && op_q == OP_ADD) |-> !used_q[slot_q])
    else $error("add claimed a used slot");

  // An add is only started on a table with room, so its walk never ends
  // on a used last slot without a hit.
  a_add_no_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_SCAN && op_q == OP_ADD && chk_vld_q && chk_last_q)
      |-> !chk_used || $past(hit_q) || hit_cond)
    else $error("add walked the whole ring without a free slot");

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the task slot table scheduler. A scoreboard object
// keeps its own copy of the slot ring, the current pointer and the pending
// count, predicts the single reply of every request transfer, and compares
// each reply transfer field by field with the oldest prediction. The stimulus
// is a short directed opening followed by random episodes that fill the
// table, serve tasks, clean it up, mix all operations, and once drive the
// pending count into saturation. Both sides idle at random.
module testbench;
  import tsts_pkg::*;

  localparam int unsigned REQUESTS      = 1800;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned SAT_BUMPS     = 270;
  localparam logic [PID_W-1:0] PID_TOP  = {PID_W{1'b1}};

  // The opcode field has two codes with no operation behind them.
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  idx;
    logic [PID_W-1:0]  pid;
    logic [PEND_W-1:0] pend;
  } reply_t;

  // Mirror of the slot ring plus the queue of replies still owed by the block.
  class slot_table_board;
    bit             used [SLOTS];
    bit [PID_W-1:0] pid_of [SLOTS];
    status_e        status_of [SLOTS];
    int unsigned    cur_slot;
    int unsigned    pending;
    int unsigned    occupied;
    reply_t         replies_due [$];
    int             mismatches;

    function void raise_pending();
      if (pending < PEND_MAX) pending++;
    endfunction

    // Lowest used slot holding pid, or SLOTS when there is none.
    function int unsigned first_slot_with(logic [PID_W-1:0] pid);
      for (int unsigned s = 0; s < SLOTS; s++)
        if (used[s] && pid_of[s] == pid) return s;
      return SLOTS;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                               logic [ST_W-1:0] st);
      reply_t      r;
      int unsigned s;
      r = '0;
      case (op)
        OP_ADD: begin
          if (occupied < SLOTS) begin
            s = (cur_slot + pending) % SLOTS;
            while (used[s]) s = (s + 1) % SLOTS;
            used[s]      = 1'b1;
            pid_of[s]    = pid;
            status_of[s] = ST_PENDING;
            raise_pending();
            occupied++;
            r.ok  = 1'b1;
            r.idx = IDX_W'(s);
          end
        end
        OP_TAKE: begin
          // One pass around the ring, starting at the current pointer.
          if (pending != 0) begin
            s = cur_slot;
            for (int unsigned n = 0; n < SLOTS; n++) begin
              if (used[s] && (status_of[s] == ST_PENDING ||
                              status_of[s] == ST_WAITING)) begin
                status_of[s] = ST_PROCESSING;
                cur_slot     = (s + 1) % SLOTS;
                pending--;
                r.ok  = 1'b1;
                r.idx = IDX_W'(s);
                break;
              end
              s = (s + 1) % SLOTS;
            end
          end
        end
        OP_SET: begin
          s = first_slot_with(pid);
          if (s < SLOTS && status_of[s] != status_e'(st)) begin
            status_of[s] = status_e'(st);
            if (st == ST_PENDING || st == ST_WAITING) raise_pending();
            r.ok  = 1'b1;
            r.idx = IDX_W'(s);
          end
        end
        OP_REMOVE: begin
          s = first_slot_with(pid);
          if (s < SLOTS) begin
            used[s] = 1'b0;
            if (occupied > 0) occupied--;
            r.ok  = 1'b1;
            r.idx = IDX_W'(s);
          end
        end
        OP_FIND: begin
          s = first_slot_with(pid);
          if (s < SLOTS) begin
            r.ok  = 1'b1;
            r.idx = IDX_W'(s);
          end
        end
        OP_BUMP: begin
          raise_pending();
          r.ok = 1'b1;
        end
        default: ;
      endcase
      // A removed slot still holds its pid, which the reply reports.
      r.pid  = (r.ok && op != OP_BUMP) ? pid_of[r.idx] : '0;
      r.pend = pending[PEND_W-1:0];
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic ok, logic [IDX_W-1:0] idx,
                              logic [PID_W-1:0] pid, logic [PEND_W-1:0] pend);
      reply_t e;
      if (replies_due.size() == 0) begin
        $error("reply transfer with no request outstanding");
        mismatches++;
        return;
      end
      e = replies_due.pop_front();
      if (ok !== e.ok) begin
        $error("ok: expected %0d, got %0d", e.ok, ok);
        mismatches++;
      end
      if (idx !== e.idx) begin
        $error("slot_index: expected %0d, got %0d", e.idx, idx);
        mismatches++;
      end
      if (pid !== e.pid) begin
        $error("found_pid: expected %h, got %h", e.pid, pid);
        mismatches++;
      end
      if (pend !== e.pend) begin
        $error("pending_now: expected %0d, got %0d", e.pend, pend);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   opcode;
  logic [PID_W-1:0]  task_pid;
  logic [ST_W-1:0]   new_status;
  logic              out_valid;
  logic              out_ready;
  logic              ok;
  logic [IDX_W-1:0]  slot_index;
  logic [PID_W-1:0]  found_pid;
  logic [PEND_W-1:0] pending_now;

  slot_table_board board = new();

  // When calm is set, neither side idles, so back-to-back transfers happen.
  bit calm;
  int unsigned requests_sent;

  task_slot_table_scheduler dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .task_pid_i    (task_pid),
    .new_status_i  (new_status),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .ok_o          (ok),
    .slot_index_o  (slot_index),
    .found_pid_o   (found_pid),
    .pending_now_o (pending_now)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Both transfers are observed at the clock edge, before any of this edge's
  // nonblocking updates land, so the sampled values are the ones the block saw.
  always @(posedge clk) begin
    if (in_valid && in_ready) board.note_request(opcode, task_pid, new_status);
    if (out_valid && out_ready) board.check_reply(ok, slot_index, found_pid, pending_now);
  end

  // Watchdog: too many cycles in a row without any transfer ends the run.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_len(int unsigned longest);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, longest);
  endfunction

  // Reply side: ready for a random run of cycles, then stalled for a while.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = idle_len(50);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Pids with few or all bits set, so that lookups hit and duplicates occur.
  function automatic logic [PID_W-1:0] corner_pid();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 22'd1;
      2: return 22'd2;
      3: return 22'd3;
      4: return PID_TOP;
      default: return PID_TOP - 22'd1;
    endcase
  endfunction

  function automatic logic [PID_W-1:0] fresh_pid();
    if ($urandom_range(0, 1) == 0) return corner_pid();
    return PID_W'($urandom_range(0, PID_TOP));
  endfunction

  // Mostly a pid that is in the table right now, otherwise a likely miss.
  function automatic logic [PID_W-1:0] pick_pid();
    int unsigned r;
    int unsigned s;
    r = $urandom_range(0, 9);
    if (r < 6 && board.occupied > 0) begin
      do s = $urandom_range(0, SLOTS - 1); while (!board.used[s]);
      return board.pid_of[s];
    end
    if (r < 8) return corner_pid();
    return PID_W'($urandom_range(0, PID_TOP));
  endfunction

  function automatic logic [ST_W-1:0] any_status();
    return ST_W'($urandom_range(0, 3));
  endfunction

  // One request transfer. Valid stays high from one request to the next when
  // there is no gap, so it is never lowered and raised in the same step.
  task automatic send(logic [OP_W-1:0] op, logic [PID_W-1:0] pid, logic [ST_W-1:0] st);
    int unsigned gap;
    gap = idle_len(40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    task_pid   <= pid;
    new_status <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op <= OP_BUMP) requests_sent++;
  endtask

  // Hold the request side until every owed reply has been transferred.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25)      send(OP_ADD, fresh_pid(), any_status());
    else if (r < 50) send(OP_TAKE, pick_pid(), any_status());
    else if (r < 70) send(OP_SET, pick_pid(), any_status());
    else if (r < 82) send(OP_REMOVE, pick_pid(), any_status());
    else if (r < 92) send(OP_FIND, pick_pid(), any_status());
    else if (r < 97) send(OP_BUMP, pick_pid(), any_status());
    else if (r < 99) send(OP_RSVD6, fresh_pid(), any_status());
    else             send(OP_RSVD7, fresh_pid(), any_status());
  endtask

  initial begin
    int unsigned episode;
    int unsigned n;
    bit          saturated;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    opcode     <= OP_ADD;
    task_pid   <= '0;
    new_status <= ST_PENDING;
    calm          = 1'b0;
    requests_sent = 0;
    saturated     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening on the empty table: misses, take with nothing pending,
    // take with a count but no task, pids at both extremes, duplicate pids,
    // a status set to the status already held, every status value, the two
    // spare opcodes, and removal of duplicates lowest slot first.
    send(OP_TAKE, '0, ST_PENDING);
    send(OP_FIND, '0, ST_PENDING);
    send(OP_REMOVE, PID_TOP, ST_FINISHED);
    send(OP_SET, PID_TOP, ST_WAITING);
    send(OP_BUMP, '0, ST_PENDING);
    send(OP_TAKE, '0, ST_PENDING);
    send(OP_ADD, '0, ST_FINISHED);
    send(OP_ADD, PID_TOP, ST_PENDING);
    send(OP_ADD, '0, ST_PENDING);
    send(OP_FIND, '0, ST_PENDING);
    send(OP_FIND, PID_TOP, ST_PENDING);
    send(OP_SET, '0, ST_PENDING);
    send(OP_SET, '0, ST_WAITING);
    send(OP_SET, PID_TOP, ST_FINISHED);
    send(OP_SET, PID_TOP, ST_PROCESSING);
    send(OP_TAKE, '0, ST_PENDING);
    send(OP_TAKE, '0, ST_PENDING);
    send(OP_TAKE, '0, ST_PENDING);
    send(OP_REMOVE, '0, ST_PENDING);
    send(OP_REMOVE, '0, ST_PENDING);
    send(OP_RSVD6, PID_TOP, ST_FINISHED);
    send(OP_RSVD7, PID_TOP, ST_FINISHED);
    send(OP_BUMP, PID_TOP, ST_FINISHED);
    send(OP_REMOVE, PID_TOP, ST_PENDING);
    drain();

    // Random episodes. The first one fills the table so the full case comes
    // early; saturation is left for late in the run, since the pending count
    // hardly comes down again once it has reached the top.
    episode = 0;
    while (requests_sent < REQUESTS) begin
      calm = ($urandom_range(0, 4) == 0);
      if (!saturated && requests_sent >= REQUESTS * 3 / 4) begin
        saturated = 1'b1;
        repeat (SAT_BUMPS) send(OP_BUMP, pick_pid(), any_status());
        repeat (8) random_request();
      end else begin
        case (episode == 0 ? 0 : $urandom_range(0, 3))
          0: begin
            // Fill to capacity, then knock on the full table a few times.
            n = SLOTS - board.occupied + $urandom_range(1, 3);
            repeat (n) begin
              if ($urandom_range(0, 7) == 0) send(OP_TAKE, pick_pid(), any_status());
              else send(OP_ADD, fresh_pid(), any_status());
            end
          end
          1: begin
            // Serve tasks and move them between statuses.
            repeat ($urandom_range(10, 30)) begin
              n = $urandom_range(0, 99);
              if (n < 55)      send(OP_TAKE, pick_pid(), any_status());
              else if (n < 85) send(OP_SET, pick_pid(), any_status());
              else             send(OP_FIND, pick_pid(), any_status());
            end
          end
          2: begin
            // Clean up, mostly by removing tasks that are present.
            repeat ($urandom_range(5, 20)) begin
              n = $urandom_range(0, 9);
              if (n < 7)      send(OP_REMOVE, pick_pid(), any_status());
              else if (n < 9) send(OP_FIND, pick_pid(), any_status());
              else            send(OP_SET, pick_pid(), any_status());
            end
          end
          default: begin
            repeat ($urandom_range(20, 60)) random_request();
          end
        endcase
      end
      episode++;
      if ($urandom_range(0, 5) == 0) drain();
    end

    calm = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.replies_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
